// File: design/otq_pkg.sv
package otq_pkg;

    // command kinds
    localparam logic [1:0] K_TICK  = 2'd0;
    localparam logic [1:0] K_ADD   = 2'd1;
    localparam logic [1:0] K_SET   = 2'd2;
    localparam logic [1:0] K_CLEAR = 2'd3;

    // reply kinds
    localparam logic [1:0] RK_FIRE = 2'd0;
    localparam logic [1:0] RK_SUM  = 2'd1;
    localparam logic [1:0] RK_ADD  = 2'd2;
    localparam logic [1:0] RK_SET  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef logic [1:0]         t_kind;
    typedef logic [31:0]        t_time;
    typedef logic [30:0]        t_ivl;
    typedef logic signed [16:0] t_count;
    typedef logic [15:0]        t_handle;
    typedef logic signed [32:0] t_ttn;

    // one timer slot
    typedef struct packed {
        t_time   due;
        t_ivl    per;
        t_count  rem;
        t_handle hnd;
        t_time   stamp;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TSCAN,
        S_FIRE,
        S_SSCAN,
        S_SUMMARY,
        S_HSCAN,
        S_SETDONE,
        S_ADD,
        S_CLEAR
    } t_state;

endpackage

// File: design/otq_if.sv
// command channel
interface otq_cmd_if;
    logic                    valid;
    logic                    ready;
    otq_pkg::t_kind          kind;
    otq_pkg::t_time          now;
    otq_pkg::t_ivl           interval_ticks;
    otq_pkg::t_count         repeat_count;
    otq_pkg::t_handle        handle;

    modport source (output valid, kind, now, interval_ticks, repeat_count, handle,
                    input ready);
    modport sink   (input valid, kind, now, interval_ticks, repeat_count, handle,
                    output ready);
endinterface

// reply channel
interface otq_rsp_if;
    logic                    valid;
    logic                    ready;
    otq_pkg::t_kind          reply_kind;
    otq_pkg::t_handle        timer_handle;
    logic [1:0]              status;
    otq_pkg::t_ttn           time_to_next;
    logic                    last;

    modport source (output valid, reply_kind, timer_handle, status, time_to_next, last,
                    input ready);
    modport sink   (input valid, reply_kind, timer_handle, status, time_to_next, last,
                    output ready);
endinterface

// File: design/ordered_timer_queue_top.sv
// Ordered timer queue: up to SLOTS timers that fire in order of due time.
// i_cmd (sink) takes one command transaction: tick, add, set interval or clear.
// o_rsp (source) gives reply transactions; the final reply of a command has last=1.
// A tick returns one fire reply per due timer (earliest due first, ties to the
// earlier scheduling) and then a summary with the time to the next timer.
// The block works on one command at a time; i_cmd.ready is high only when idle.
// Set interval and tick walk the slot table one slot per cycle through a shared
// due/stamp comparator; add and clear do not scan the table.
// Replies leave through a single output register; a command may be accepted
// while the last reply of the previous one still waits there.
// When the receiver stalls, the sequencer holds before its next reply.
// Reset (synchronous, active low) frees every slot and zeroes the handle and
// order counters.
module ordered_timer_queue_top #(
    parameter int SLOTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    otq_cmd_if.sink         i_cmd,
    otq_rsp_if.source       o_rsp
);
    import otq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [SLOTS-1:0]  r_fired, n_fired;
    t_slot             r_slot [SLOTS];

    // latched command
    t_time             r_now;
    t_ivl              r_ivl;
    t_count            r_rc;
    t_handle           r_hin;

    // best candidate of the current scan
    logic              r_bfound, n_bfound;
    logic [IW-1:0]     r_bidx, n_bidx;
    t_slot             r_best, n_best;

    t_handle           r_next_handle, n_next_handle;
    t_time             r_next_stamp, n_next_stamp;

    // output register
    logic              r_o_valid, n_o_valid;
    t_kind             r_o_kind, n_o_kind;
    t_handle           r_o_handle, n_o_handle;
    logic [1:0]        r_o_status, n_o_status;
    t_ttn              r_o_ttn, n_o_ttn;
    logic              r_o_last, n_o_last;

    // slot write port
    logic              w_en;
    logic [IW-1:0]     w_idx;
    t_slot             w_data;

    t_slot             rd;
    logic              emit_ok;
    logic              elig;
    logic              better;
    logic              take;
    logic [32:0]       sum;
    t_time             sat_due;
    t_count            rem_dec;
    logic              free_any;
    logic [IW-1:0]     free_idx;

    assign rd      = r_slot[r_idx];
    assign emit_ok = !r_o_valid || o_rsp.ready;
    assign better  = !r_bfound || (rd.due < r_best.due) ||
                     ((rd.due == r_best.due) && (rd.stamp < r_best.stamp));
    assign sum     = {1'b0, r_now} + {2'b0, r_best.per};
    assign sat_due = sum[32] ? '1 : sum[31:0];
    assign rem_dec = r_best.rem - 17'sd1;

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.reply_kind   = r_o_kind;
    assign o_rsp.timer_handle = r_o_handle;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.time_to_next = r_o_ttn;
    assign o_rsp.last         = r_o_last;

    // scan eligibility of the slot under the index
    always_comb begin
        unique case (r_state)
            S_TSCAN: elig = r_valid[r_idx] && !r_fired[r_idx] && (rd.due <= r_now);
            S_SSCAN: elig = r_valid[r_idx];
            S_HSCAN: elig = r_valid[r_idx] && (rd.hnd == r_hin);
            default: elig = 1'b0;
        endcase
    end
    assign take = elig && better;

    // first free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_valid       = r_valid;
        n_fired       = r_fired;
        n_bfound      = r_bfound;
        n_bidx        = r_bidx;
        n_best        = r_best;
        n_next_handle = r_next_handle;
        n_next_stamp  = r_next_stamp;
        n_o_valid     = r_o_valid && !o_rsp.ready;
        n_o_kind      = r_o_kind;
        n_o_handle    = r_o_handle;
        n_o_status    = r_o_status;
        n_o_ttn       = r_o_ttn;
        n_o_last      = r_o_last;
        w_en          = 1'b0;
        w_idx         = r_bidx;
        w_data        = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_idx    = '0;
                    n_bfound = 1'b0;
                    unique case (i_cmd.kind)
                        K_TICK: begin
                            n_fired = '0;
                            n_state = S_TSCAN;
                        end
                        K_ADD:   n_state = S_ADD;
                        K_SET:   n_state = S_HSCAN;
                        K_CLEAR: n_state = S_CLEAR;
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_TSCAN, S_SSCAN, S_HSCAN: begin
                if (take) begin
                    n_bfound = 1'b1;
                    n_bidx   = r_idx;
                    n_best   = rd;
                end
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    unique case (r_state)
                        S_TSCAN: begin
                            if (r_bfound || take) begin
                                n_state = S_FIRE;
                            end else begin
                                n_bfound = 1'b0;
                                n_state  = S_SSCAN;
                            end
                        end
                        S_SSCAN: n_state = S_SUMMARY;
                        default: n_state = S_SETDONE;
                    endcase
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_FIRE: begin
                if (emit_ok) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = RK_FIRE;
                    n_o_handle = r_best.hnd;
                    n_o_status = ST_OK;
                    n_o_ttn    = '0;
                    n_o_last   = 1'b0;
                    n_fired[r_bidx] = 1'b1;
                    w_en       = 1'b1;
                    w_data.due   = sat_due;
                    w_data.stamp = r_next_stamp;
                    if (r_best.rem < 0) begin
                        n_next_stamp = r_next_stamp + 1'b1;
                    end else begin
                        w_data.rem = rem_dec;
                        if (rem_dec <= 0) begin
                            n_valid[r_bidx] = 1'b0;
                        end else begin
                            n_next_stamp = r_next_stamp + 1'b1;
                        end
                    end
                    n_bfound = 1'b0;
                    n_idx    = '0;
                    n_state  = S_TSCAN;
                end
            end

            S_SUMMARY: begin
                if (emit_ok) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = RK_SUM;
                    n_o_handle = '0;
                    n_o_status = ST_OK;
                    n_o_last   = 1'b1;
                    if (!r_bfound) begin
                        n_o_ttn = '1;
                    end else if (r_best.due < r_now) begin
                        n_o_ttn = '0;
                    end else begin
                        n_o_ttn = {1'b0, r_best.due - r_now};
                    end
                    n_state = S_IDLE;
                end
            end

            S_SETDONE: begin
                if (emit_ok) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = RK_SET;
                    n_o_handle = r_hin;
                    n_o_ttn    = '0;
                    n_o_last   = 1'b1;
                    n_o_status = r_bfound ? ST_OK : ST_NOTFOUND;
                    w_en       = r_bfound;
                    w_data.per = r_ivl;
                    n_state    = S_IDLE;
                end
            end

            S_ADD: begin
                if (emit_ok) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = RK_ADD;
                    n_o_handle = '0;
                    n_o_ttn    = '0;
                    n_o_last   = 1'b1;
                    w_idx      = free_idx;
                    w_data.per = r_ivl;
                    w_data.rem = r_rc[16] ? -17'sd1 : r_rc;
                    w_data.hnd = r_next_handle;
                    w_data.stamp = r_next_stamp;
                    w_data.due = ({1'b0, r_now} + {2'b0, r_ivl}) > 33'h0FFFFFFFF ? '1 :
                                 r_now + {1'b0, r_ivl};
                    if (r_rc == 0) begin
                        n_o_status = ST_ZERO;
                    end else if (!free_any) begin
                        n_o_status = ST_FULL;
                    end else begin
                        n_o_status        = ST_OK;
                        n_o_handle        = r_next_handle;
                        w_en              = 1'b1;
                        n_valid[free_idx] = 1'b1;
                        n_next_handle     = r_next_handle + 1'b1;
                        n_next_stamp      = r_next_stamp + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end

            S_CLEAR: begin
                if (emit_ok) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = RK_SET;
                    n_o_handle = '0;
                    n_o_status = ST_OK;
                    n_o_ttn    = '0;
                    n_o_last   = 1'b1;
                    n_valid    = '0;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_next_handle <= '0;
            r_next_stamp  <= '0;
            r_o_valid     <= 1'b0;
            r_bfound      <= 1'b0;
            r_idx         <= '0;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_next_handle <= n_next_handle;
            r_next_stamp  <= n_next_stamp;
            r_o_valid     <= n_o_valid;
            r_bfound      <= n_bfound;
            r_idx         <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fired    <= n_fired;
        r_bidx     <= n_bidx;
        r_best     <= n_best;
        r_o_kind   <= n_o_kind;
        r_o_handle <= n_o_handle;
        r_o_status <= n_o_status;
        r_o_ttn    <= n_o_ttn;
        r_o_last   <= n_o_last;
        if (i_cmd.valid && i_cmd.ready) begin
            r_now <= i_cmd.now;
            r_ivl <= i_cmd.interval_ticks;
            r_rc  <= i_cmd.repeat_count;
            r_hin <= i_cmd.handle;
        end
        if (w_en) begin
            r_slot[w_idx] <= w_data;
        end
    end

`ifndef SYNTHESIS
    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.reply_kind == RK_FIRE) |-> !o_rsp.last)
        else $error("fire reply marked last");

    a_ttn_only_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.reply_kind != RK_SUM) |-> (o_rsp.time_to_next == 0))
        else $error("time_to_next outside summary");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != S_IDLE))
        else $error("command accepted without starting work");
`endif

endmodule
